@@ rtl/wfr_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wfr_pkg
// Types, constants and the CRC-8 step shared by the frame receiver.
// ---------------------------------------------------------------------------
package wfr_pkg;

	localparam int FRAME_BUFFER_BYTES = 256;

	localparam logic [7:0] MARK_FRAME  = 8'hC0;
	localparam logic [7:0] MARK_ESC    = 8'hDB;
	localparam logic [7:0] ESC_FRAME   = 8'hDC;
	localparam logic [7:0] ESC_ESC     = 8'hDD;
	localparam logic [7:0] CRC_POLY    = 8'h31;
	localparam logic [7:0] MAX_PAYLOAD = 8'(FRAME_BUFFER_BYTES - 5);

	localparam logic [15:0] TIMEOUT_RESET = 16'd100;

	typedef enum logic [0:0] {
		CFG_OWN_ADDRESS  = 1'b0,
		CFG_TIMEOUT      = 1'b1
	} cfg_index_t;

	typedef enum logic [2:0] {
		ST_PAYLOAD = 3'd0,
		ST_GOOD    = 3'd1,
		ST_CRC     = 3'd2,
		ST_INVALID = 3'd3,
		ST_TIMEOUT = 3'd4
	} status_t;

	// crc-8, msb first, no reflection
	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] d);
		logic [7:0] c;
		c = crc ^ d;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

	localparam logic [7:0] CRC_INIT = crc8_step(8'h00, MARK_FRAME);

endpackage

@@ rtl/wake_frame_receiver_core.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wake_frame_receiver_core
// Deframer for a byte-stuffed serial protocol with CRC-8 check.
//
// Input channel (in_valid/in_ready): each transfer is either a line byte
// (kind 0, raw_byte) or a one millisecond tick (kind 1). 0xC0 opens a frame,
// 0xDB escapes the next byte. Address, command, size, payload and CRC follow.
// Output channel (out_valid/out_ready): zero or one result per input item:
// a payload byte, or the frame outcome (good, CRC error, invalid, timeout)
// with the address, command and declared length of the frame.
// Configuration: cfg_we/cfg_index/cfg_data write own_address (index 0) and
// timeout_ticks (index 1). The user must write them only while the block is
// idle; the block itself does not enforce this. An accepted item sits in
// the input register while the per-byte decode and CRC feed the result
// register. Throughput is one item per cycle while out_ready is not low.
// Reset clears the frame state, own_address to 0 and timeout_ticks to 100.
// When out_ready is low with a result pending, the input register holds its
// item and in_ready drops once that register is full.
// ---------------------------------------------------------------------------
module wake_frame_receiver_core
	import wfr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        kind,
	input  logic [7:0]  raw_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [7:0]  payload_byte,
	output logic [7:0]  frame_address,
	output logic [7:0]  frame_command,
	output logic [7:0]  payload_length
);

	logic [7:0]  own_address_q;
	logic [15:0] timeout_ticks_q;

	logic        valid_s1;
	logic        kind_s1;
	logic [7:0]  byte_s1;

	logic        in_frame_q, escape_pending_q, stray_reported_q, address_accepted_q;
	logic [7:0]  byte_count_q, running_crc_q;
	logic [7:0]  held_address_q, held_command_q, held_size_q;
	logic [15:0] idle_ticks_q;

	logic        in_frame_d, escape_pending_d, stray_reported_d, address_accepted_d;
	logic [7:0]  byte_count_d, running_crc_d;
	logic [7:0]  held_address_d, held_command_d, held_size_d;
	logic [15:0] idle_ticks_d;

	logic        out_valid_q;
	status_t     status_q;
	logic [7:0]  payload_byte_q, frame_address_q, frame_command_q, payload_length_q;

	logic        advance;
	logic        emit;
	logic        framed;
	status_t     r_status;
	logic [7:0]  r_payload;
	logic        take;
	logic [7:0]  take_data;
	logic [8:0]  frame_end;

	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_address_q   <= 8'h00;
			timeout_ticks_q <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_OWN_ADDRESS: own_address_q   <= cfg_data[7:0];
				CFG_TIMEOUT:     timeout_ticks_q <= cfg_data;
				default:         ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			kind_s1 <= kind;
			byte_s1 <= raw_byte;
		end
	end

	assign frame_end = 9'd3 + {1'b0, held_size_q};

	always_comb begin
		in_frame_d         = in_frame_q;
		escape_pending_d   = escape_pending_q;
		stray_reported_d   = stray_reported_q;
		address_accepted_d = address_accepted_q;
		byte_count_d       = byte_count_q;
		running_crc_d      = running_crc_q;
		held_address_d     = held_address_q;
		held_command_d     = held_command_q;
		held_size_d        = held_size_q;
		idle_ticks_d       = idle_ticks_q;
		emit               = 1'b0;
		framed             = 1'b1;
		r_status           = ST_PAYLOAD;
		r_payload          = 8'h00;
		take               = 1'b0;
		take_data          = byte_s1;

		if (kind_s1) begin
			if (in_frame_q) begin
				if (idle_ticks_q != 16'hFFFF) begin
					idle_ticks_d = idle_ticks_q + 16'd1;
				end
				if (idle_ticks_d > timeout_ticks_q) begin
					in_frame_d       = 1'b0;
					escape_pending_d = 1'b0;
					stray_reported_d = 1'b0;
					idle_ticks_d     = 16'h0000;
					emit             = 1'b1;
					r_status         = ST_TIMEOUT;
				end
			end
		end else begin
			idle_ticks_d = 16'h0000;
			priority if (byte_s1 == MARK_FRAME) begin
				in_frame_d         = 1'b1;
				escape_pending_d   = 1'b0;
				stray_reported_d   = 1'b0;
				byte_count_d       = 8'h00;
				running_crc_d      = CRC_INIT;
				held_address_d     = 8'h00;
				held_command_d     = 8'h00;
				held_size_d        = 8'h00;
				address_accepted_d = 1'b1;
			end else if (!in_frame_q) begin
				if (!stray_reported_q) begin
					stray_reported_d = 1'b1;
					emit             = 1'b1;
					framed           = 1'b0;
					r_status         = ST_INVALID;
				end
			end else if (escape_pending_q) begin
				escape_pending_d = 1'b0;
				priority if (byte_s1 == ESC_FRAME) begin
					take      = 1'b1;
					take_data = MARK_FRAME;
				end else if (byte_s1 == ESC_ESC) begin
					take      = 1'b1;
					take_data = MARK_ESC;
				end else begin
					in_frame_d       = 1'b0;
					stray_reported_d = 1'b1;
					emit             = 1'b1;
					r_status         = ST_INVALID;
				end
			end else if (byte_s1 == MARK_ESC) begin
				escape_pending_d = 1'b1;
			end else begin
				take = 1'b1;
			end

			if (take) begin
				running_crc_d = crc8_step(running_crc_q, take_data);
				priority if (byte_count_q == 8'd0) begin
					held_address_d     = take_data;
					address_accepted_d = (own_address_q == 8'h00) || (take_data == 8'h00)
						|| (take_data == own_address_q);
					byte_count_d       = 8'd1;
				end else if (byte_count_q == 8'd1) begin
					held_command_d = take_data;
					byte_count_d   = 8'd2;
				end else if (byte_count_q == 8'd2) begin
					if (take_data > MAX_PAYLOAD) begin
						in_frame_d       = 1'b0;
						escape_pending_d = 1'b0;
						stray_reported_d = 1'b1;
						emit             = 1'b1;
						r_status         = ST_INVALID;
					end else begin
						held_size_d  = take_data;
						byte_count_d = 8'd3;
					end
				end else if ({1'b0, byte_count_q} < frame_end) begin
					byte_count_d = byte_count_q + 8'd1;
					if (address_accepted_q) begin
						emit      = 1'b1;
						r_status  = ST_PAYLOAD;
						r_payload = take_data;
					end
				end else begin
					in_frame_d       = 1'b0;
					escape_pending_d = 1'b0;
					stray_reported_d = 1'b0;
					if (running_crc_d != 8'h00) begin
						emit     = 1'b1;
						r_status = ST_CRC;
					end else if (address_accepted_q) begin
						emit     = 1'b1;
						r_status = ST_GOOD;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q         <= 1'b0;
			escape_pending_q   <= 1'b0;
			stray_reported_q   <= 1'b0;
			address_accepted_q <= 1'b1;
			byte_count_q       <= 8'h00;
			running_crc_q      <= CRC_INIT;
			held_address_q     <= 8'h00;
			held_command_q     <= 8'h00;
			held_size_q        <= 8'h00;
			idle_ticks_q       <= 16'h0000;
			out_valid_q        <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && emit;
			if (valid_s1) begin
				in_frame_q         <= in_frame_d;
				escape_pending_q   <= escape_pending_d;
				stray_reported_q   <= stray_reported_d;
				address_accepted_q <= address_accepted_d;
				byte_count_q       <= byte_count_d;
				running_crc_q      <= running_crc_d;
				held_address_q     <= held_address_d;
				held_command_q     <= held_command_d;
				held_size_q        <= held_size_d;
				idle_ticks_q       <= idle_ticks_d;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (advance && valid_s1 && emit) begin
			status_q         <= r_status;
			payload_byte_q   <= r_payload;
			frame_address_q  <= framed ? held_address_q : 8'h00;
			frame_command_q  <= framed ? held_command_q : 8'h00;
			payload_length_q <= framed ? held_size_q : 8'h00;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign payload_byte   = payload_byte_q;
	assign frame_address  = frame_address_q;
	assign frame_command  = frame_command_q;
	assign payload_length = payload_length_q;

endmodule
